FILE: design/bps_pkg.sv
`timescale 1ns / 1ps
package bps_pkg;

	// Configuration register map
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEC_COEF = 3'd0,
		REG_DIFF_COEF = 3'd1,
		REG_SHININESS = 3'd2,
		REG_MAT_RED   = 3'd3,
		REG_MAT_GREEN = 3'd4,
		REG_MAT_BLUE  = 3'd5
	} cfg_reg_t;

	// Cosine in Q.16, power result in Q.16 capped at 2^40
	localparam int COS_W = 32;
	localparam int POW_W = 41;
	localparam int EXP_W = 16;

	// 2^(2^-k) in Q1.30, each one the truncated square root of the one before
	function automatic logic [30:0] exp2_factor(input int k);
		logic [63:0] fac;
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bit_v;
		fac = 64'd1 << 31;
		for (int i = 0; i < k; i++) begin
			x = fac << 30;
			res = '0;
			bit_v = 64'd1 << 62;
			for (int j = 0; j < 32; j++) begin
				if (x >= res + bit_v) begin
					x = x - (res + bit_v);
					res = (res >> 1) + bit_v;
				end else begin
					res = res >> 1;
				end
				bit_v = bit_v >> 2;
			end
			fac = res;
		end
		return fac[30:0];
	endfunction

endpackage

FILE: design/bps_half_dot.sv
`timescale 1ns / 1ps
// Half vector normalization and clamped dot with the normal.
// Squares, sum, one root bit per stage, one quotient bit per stage per lane,
// then sign, products and dot.
module bps_half_dot #(
	parameter int COMPONENT_BITS = 16,
	parameter int SIDE_W = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [COMPONENT_BITS:0]   sum_x,
	input  logic signed [COMPONENT_BITS:0]   sum_y,
	input  logic signed [COMPONENT_BITS:0]   sum_z,
	input  logic signed [COMPONENT_BITS-1:0] nrm_x,
	input  logic signed [COMPONENT_BITS-1:0] nrm_y,
	input  logic signed [COMPONENT_BITS-1:0] nrm_z,
	input  logic [SIDE_W-1:0]                in_side,
	output logic                             out_valid,
	output logic [bps_pkg::COS_W-1:0]        cos_q16,
	output logic [SIDE_W-1:0]                out_side
);
	import bps_pkg::*;

	localparam int CB  = COMPONENT_BITS;
	localparam int F   = CB - 2;
	localparam int LW  = CB + 1;
	localparam int QW  = 2 * CB + 2;
	localparam int QTW = F + 1;
	localparam int NW  = CB + 1 + F;
	localparam int DW  = NW + 1;
	localparam int HW  = F + 2;
	localparam int PW  = HW + CB;
	localparam int DTW = PW + 2;
	localparam int CW  = DTW - F;
	localparam int SH  = F - 16;
	localparam int LSH = (SH < 0) ? -SH : 0;
	localparam int RSH = (SH > 0) ? SH : 0;

	typedef struct packed {
		logic [2:0][CB:0]   mag;
		logic [2:0]         neg;
		logic [2:0][CB-1:0] nrm;
		logic               zero;
		logic [SIDE_W-1:0]  side;
	} carry_t;

	// stage A: magnitudes and squares
	logic             vld_a_s1;
	carry_t           cr_a_s1;
	logic [2:0][QW-1:0] sq_a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_s1 <= 1'b0;
		end else begin
			vld_a_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		logic [CB:0] mx, my, mz;
		mx = sum_x[CB] ? (CB+1)'(-sum_x) : sum_x;
		my = sum_y[CB] ? (CB+1)'(-sum_y) : sum_y;
		mz = sum_z[CB] ? (CB+1)'(-sum_z) : sum_z;
		cr_a_s1.mag  <= {mz, my, mx};
		cr_a_s1.neg  <= {sum_z[CB], sum_y[CB], sum_x[CB]};
		cr_a_s1.nrm  <= {nrm_z, nrm_y, nrm_x};
		cr_a_s1.zero <= 1'b0;
		cr_a_s1.side <= in_side;
		sq_a_s1[0]   <= QW'(mx) * QW'(mx);
		sq_a_s1[1]   <= QW'(my) * QW'(my);
		sq_a_s1[2]   <= QW'(mz) * QW'(mz);
	end

	// square root: element 0 holds the sum of squares, one result bit per stage
	logic            vld_sq_sk  [0:LW];
	carry_t          cr_sq_sk   [0:LW];
	logic [QW-1:0]   rem_sq_sk  [0:LW];
	logic [QW-1:0]   root_sq_sk [0:LW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sq_sk[0] <= 1'b0;
		end else begin
			vld_sq_sk[0] <= vld_a_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic [QW-1:0] q;
		q = sq_a_s1[0] + sq_a_s1[1] + sq_a_s1[2];
		rem_sq_sk[0]  <= q;
		root_sq_sk[0] <= '0;
		cr_sq_sk[0]   <= '{mag: cr_a_s1.mag, neg: cr_a_s1.neg, nrm: cr_a_s1.nrm,
			zero: (q == '0), side: cr_a_s1.side};
	end

	for (genvar j = 0; j < LW; j++) begin : g_sqrt
		localparam logic [QW-1:0] BITC = QW'(1) << (2 * (LW - 1 - j));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq_sk[j+1] <= 1'b0;
			end else begin
				vld_sq_sk[j+1] <= vld_sq_sk[j];
			end
		end

		always_ff @(posedge clk) begin
			logic [QW-1:0] trial;
			trial = root_sq_sk[j] + BITC;
			cr_sq_sk[j+1] <= cr_sq_sk[j];
			if (rem_sq_sk[j] >= trial) begin
				rem_sq_sk[j+1]  <= rem_sq_sk[j] - trial;
				root_sq_sk[j+1] <= (root_sq_sk[j] >> 1) + BITC;
			end else begin
				rem_sq_sk[j+1]  <= rem_sq_sk[j];
				root_sq_sk[j+1] <= root_sq_sk[j] >> 1;
			end
		end
	end

	// restoring divide, three lanes, element 0 fed straight from the root
	logic                   vld_dv_sk [0:QTW];
	carry_t                 cr_dv_sk  [0:QTW];
	logic [LW-1:0]          len_dv_sk [0:QTW];
	logic [2:0][DW-1:0]     rem_dv_sk [0:QTW];
	logic [2:0][QTW-1:0]    qt_dv_sk  [0:QTW];

	always_comb begin
		vld_dv_sk[0] = vld_sq_sk[LW];
		cr_dv_sk[0]  = cr_sq_sk[LW];
		len_dv_sk[0] = root_sq_sk[LW][LW-1:0];
		for (int i = 0; i < 3; i++) begin
			rem_dv_sk[0][i] = DW'({cr_sq_sk[LW].mag[i], {F{1'b0}}});
			qt_dv_sk[0][i]  = '0;
		end
	end

	for (genvar k = 0; k < QTW; k++) begin : g_div
		localparam int KB = QTW - 1 - k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv_sk[k+1] <= 1'b0;
			end else begin
				vld_dv_sk[k+1] <= vld_dv_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			logic [DW-1:0] dvs;
			dvs = DW'(len_dv_sk[k]) << KB;
			cr_dv_sk[k+1]  <= cr_dv_sk[k];
			len_dv_sk[k+1] <= len_dv_sk[k];
			for (int i = 0; i < 3; i++) begin
				if (rem_dv_sk[k][i] >= dvs) begin
					rem_dv_sk[k+1][i]    <= rem_dv_sk[k][i] - dvs;
					qt_dv_sk[k+1][i]     <= qt_dv_sk[k][i] | (QTW'(1) << KB);
				end else begin
					rem_dv_sk[k+1][i]    <= rem_dv_sk[k][i];
					qt_dv_sk[k+1][i]     <= qt_dv_sk[k][i];
				end
			end
		end
	end

	// signed half vector, products, dot and clamp
	logic                      vld_h_s1, vld_p_s1, vld_d_s1;
	carry_t                    cr_h_s1, cr_p_s1;
	logic signed [HW-1:0]      h_s1 [0:2];
	logic signed [PW-1:0]      p_s1 [0:2];
	logic [COS_W-1:0]          cos_d_s1;
	logic [SIDE_W-1:0]         side_d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_h_s1 <= 1'b0;
			vld_p_s1 <= 1'b0;
			vld_d_s1 <= 1'b0;
		end else begin
			vld_h_s1 <= vld_dv_sk[QTW];
			vld_p_s1 <= vld_h_s1;
			vld_d_s1 <= vld_p_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [HW-1:0] hq;
		logic signed [DTW-1:0] d;
		logic [CW-1:0] c;
		cr_h_s1 <= cr_dv_sk[QTW];
		for (int i = 0; i < 3; i++) begin
			hq = $signed({1'b0, qt_dv_sk[QTW][i]});
			h_s1[i] <= cr_dv_sk[QTW].neg[i] ? -hq : hq;
		end
		cr_p_s1 <= cr_h_s1;
		for (int i = 0; i < 3; i++) begin
			p_s1[i] <= PW'(h_s1[i]) * PW'($signed(cr_h_s1.nrm[i]));
		end
		d = DTW'(p_s1[0]) + DTW'(p_s1[1]) + DTW'(p_s1[2]);
		c = d[DTW-1:F];
		if (cr_p_s1.zero || d <= 0) begin
			cos_d_s1 <= '0;
		end else begin
			cos_d_s1 <= (COS_W'(c) << LSH) >> RSH;
		end
		side_d_s1 <= cr_p_s1.side;
	end

	assign out_valid = vld_d_s1;
	assign cos_q16   = cos_d_s1;
	assign out_side  = side_d_s1;

endmodule

FILE: design/bps_pow.sv
`timescale 1ns / 1ps
// cos^e by log2 (16 squaring stages) and exp2 (16 factor stages).
module bps_pow #(
	parameter int SIDE_W = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [bps_pkg::COS_W-1:0]  base,
	input  logic [bps_pkg::EXP_W-1:0]  expo,
	input  logic [SIDE_W-1:0]          in_side,
	output logic                       out_valid,
	output logic [bps_pkg::POW_W-1:0]  pow_q16,
	output logic [SIDE_W-1:0]          out_side
);
	import bps_pkg::*;

	localparam int PRW = 38;
	localparam logic [POW_W-1:0] POW_CAP = POW_W'(1) << 40;
	localparam logic [POW_W-1:0] POW_ONE = POW_W'(1) << 16;

	typedef struct packed {
		logic [4:0]        msb;
		logic [EXP_W-1:0]  e;
		logic              e_zero;
		logic              b_zero;
		logic [SIDE_W-1:0] side;
	} lg_carry_t;

	typedef struct packed {
		logic              e_zero;
		logic              b_zero;
		logic [SIDE_W-1:0] side;
	} ex_carry_t;

	// leading one, then normalize into Q1.30
	logic            vld_s1, vld_s2;
	lg_carry_t       cr_s1, cr_s2;
	logic [COS_W-1:0] b_s1;
	logic [30:0]     m_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic [4:0] p;
		logic [61:0] sh;
		p = '0;
		for (int i = 0; i < COS_W; i++) begin
			if (base[i]) p = 5'(i);
		end
		b_s1         <= base;
		cr_s1.msb    <= p;
		cr_s1.e      <= expo;
		cr_s1.e_zero <= (expo == '0);
		cr_s1.b_zero <= (base == '0);
		cr_s1.side   <= in_side;
		sh = {b_s1, 30'b0} >> cr_s1.msb;
		m_s2  <= sh[30:0];
		cr_s2 <= cr_s1;
	end

	// log2 fraction, one bit per squaring
	logic        vld_lg_sk  [0:16];
	lg_carry_t   cr_lg_sk   [0:16];
	logic [30:0] m_lg_sk    [0:16];
	logic [15:0] frac_lg_sk [0:16];

	always_comb begin
		vld_lg_sk[0]  = vld_s2;
		cr_lg_sk[0]   = cr_s2;
		m_lg_sk[0]    = m_s2;
		frac_lg_sk[0] = '0;
	end

	for (genvar j = 0; j < 16; j++) begin : g_log
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_lg_sk[j+1] <= 1'b0;
			end else begin
				vld_lg_sk[j+1] <= vld_lg_sk[j];
			end
		end

		always_ff @(posedge clk) begin
			logic [61:0] sq;
			logic [31:0] m2;
			sq = 62'(m_lg_sk[j]) * 62'(m_lg_sk[j]);
			m2 = sq[61:30];
			cr_lg_sk[j+1]   <= cr_lg_sk[j];
			m_lg_sk[j+1]    <= m2[31] ? m2[31:1] : m2[30:0];
			frac_lg_sk[j+1] <= {frac_lg_sk[j][14:0], m2[31]};
		end
	end

	// t = log2(b) * e, kept before the divide by 2^8
	logic              vld_m_s1;
	ex_carry_t         cr_m_s1;
	logic signed [PRW-1:0] prod_m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m_s1 <= 1'b0;
		end else begin
			vld_m_s1 <= vld_lg_sk[16];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [20:0] lg;
		lg = $signed({~cr_lg_sk[16].msb[4], cr_lg_sk[16].msb[3:0], frac_lg_sk[16]});
		prod_m_s1 <= PRW'(lg) * PRW'($signed({1'b0, cr_lg_sk[16].e}));
		cr_m_s1   <= '{e_zero: cr_lg_sk[16].e_zero, b_zero: cr_lg_sk[16].b_zero,
			side: cr_lg_sk[16].side};
	end

	// 2^frac as a product of constant factors
	logic                 vld_ex_sk  [0:16];
	ex_carry_t            cr_ex_sk   [0:16];
	logic [30:0]          mant_ex_sk [0:16];
	logic signed [13:0]   ip_ex_sk   [0:16];
	logic [15:0]          f_ex_sk    [0:16];

	always_comb begin
		vld_ex_sk[0]  = vld_m_s1;
		cr_ex_sk[0]   = cr_m_s1;
		mant_ex_sk[0] = 31'd1 << 30;
		ip_ex_sk[0]   = prod_m_s1[PRW-1:24];
		f_ex_sk[0]    = prod_m_s1[23:8];
	end

	for (genvar j = 0; j < 16; j++) begin : g_exp
		localparam logic [30:0] FAC = exp2_factor(j + 1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_ex_sk[j+1] <= 1'b0;
			end else begin
				vld_ex_sk[j+1] <= vld_ex_sk[j];
			end
		end

		always_ff @(posedge clk) begin
			logic [61:0] pr;
			pr = 62'(mant_ex_sk[j]) * 62'(FAC);
			cr_ex_sk[j+1] <= cr_ex_sk[j];
			ip_ex_sk[j+1] <= ip_ex_sk[j];
			f_ex_sk[j+1]  <= f_ex_sk[j];
			mant_ex_sk[j+1] <= f_ex_sk[j][15-j] ? pr[60:30] : mant_ex_sk[j];
		end
	end

	// scale by 2^ip, cap, special cases
	logic              vld_o_s1;
	logic [POW_W-1:0]  pw_o_s1;
	logic [SIDE_W-1:0] side_o_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_s1 <= 1'b0;
		end else begin
			vld_o_s1 <= vld_ex_sk[16];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [14:0] ipx;
		logic signed [14:0] shv;
		logic [POW_W-1:0]   r;
		ipx = {ip_ex_sk[16][13], ip_ex_sk[16]};
		if (ipx <= 15'sd14) begin
			shv = 15'sd14 - ipx;
			r = (shv >= 15'sd31) ? '0 : POW_W'(mant_ex_sk[16] >> shv[4:0]);
		end else if (ipx > 15'sd24) begin
			r = POW_CAP;
		end else begin
			shv = ipx - 15'sd14;
			r = POW_W'(mant_ex_sk[16]) << shv[3:0];
		end
		if (r > POW_CAP) r = POW_CAP;
		if (cr_ex_sk[16].e_zero) begin
			pw_o_s1 <= POW_ONE;
		end else if (cr_ex_sk[16].b_zero) begin
			pw_o_s1 <= '0;
		end else begin
			pw_o_s1 <= r;
		end
		side_o_s1 <= cr_ex_sk[16].side;
	end

	assign out_valid = vld_o_s1;
	assign pow_q16   = pw_o_s1;
	assign out_side  = side_o_s1;

endmodule

FILE: design/blinn_phong_shade_unit.sv
`timescale 1ns / 1ps
// Blinn-Phong shading of one light sample per transaction.
//
// Input: pulse start with the light color, normal, light and view directions
// and geometry factor on their ports; a transaction is taken at every rising
// edge with start high and busy low. busy stays low: one transaction per cycle.
// Output: done is high for one cycle with out_red/green/blue; the receiver
// cannot stall, so the pipeline never holds and nothing waits on it.
// The pipeline takes one item per cycle. Its depth is set by the root (one bit
// per stage), the divider (one quotient bit per stage, three lanes) and the 16
// log2 squarings plus the 16 exp2 factor multiplies.
// Config: cfg_valid/cfg_ready write channel, cfg_ready always high; index 0..5
// selects spec_coef, diff_coef, shininess, mat_red/green/blue, other indexes
// are ignored. Write only while no transaction is in flight.
// Reset: clears all stage valid bits and loads the register defaults; no
// result comes out until new transactions are taken.
module blinn_phong_shade_unit #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [47:0]                         light_rgb,
	input  logic signed [COMPONENT_BITS-1:0]    norm_x,
	input  logic signed [COMPONENT_BITS-1:0]    norm_y,
	input  logic signed [COMPONENT_BITS-1:0]    norm_z,
	input  logic signed [COMPONENT_BITS-1:0]    light_x,
	input  logic signed [COMPONENT_BITS-1:0]    light_y,
	input  logic signed [COMPONENT_BITS-1:0]    light_z,
	input  logic signed [COMPONENT_BITS-1:0]    view_x,
	input  logic signed [COMPONENT_BITS-1:0]    view_y,
	input  logic signed [COMPONENT_BITS-1:0]    view_z,
	input  logic [15:0]                         geom_factor,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [15:0]                         cfg_data,
	output logic                                done,
	output logic [15:0]                         out_red,
	output logic [15:0]                         out_green,
	output logic [15:0]                         out_blue
);
	import bps_pkg::*;

	localparam int CB     = COMPONENT_BITS;
	localparam int SIDE_W = 64;
	localparam logic [44:0] SPEC_CAP = 45'd1 << 44;

	// config registers
	logic [15:0] spec_coef_q, diff_coef_q, shininess_q;
	logic [15:0] mat_red_q, mat_green_q, mat_blue_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_coef_q <= 16'd0;
			diff_coef_q <= 16'd16384;
			shininess_q <= 16'd2560;
			mat_red_q   <= 16'd4096;
			mat_green_q <= 16'd4096;
			mat_blue_q  <= 16'd4096;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SPEC_COEF: spec_coef_q <= cfg_data;
				REG_DIFF_COEF: diff_coef_q <= cfg_data;
				REG_SHININESS: shininess_q <= cfg_data;
				REG_MAT_RED:   mat_red_q   <= cfg_data;
				REG_MAT_GREEN: mat_green_q <= cfg_data;
				REG_MAT_BLUE:  mat_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1: l + v, carry normal, color and geometry alongside
	logic                  vld_s1;
	logic signed [CB:0]    sum_x_s1, sum_y_s1, sum_z_s1;
	logic signed [CB-1:0]  nx_s1, ny_s1, nz_s1;
	logic [SIDE_W-1:0]     side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sum_x_s1 <= (CB+1)'(light_x) + (CB+1)'(view_x);
		sum_y_s1 <= (CB+1)'(light_y) + (CB+1)'(view_y);
		sum_z_s1 <= (CB+1)'(light_z) + (CB+1)'(view_z);
		nx_s1    <= norm_x;
		ny_s1    <= norm_y;
		nz_s1    <= norm_z;
		side_s1  <= {light_rgb, geom_factor};
	end

	// half vector and cosine
	logic               hd_valid;
	logic [COS_W-1:0]   hd_cos;
	logic [SIDE_W-1:0]  hd_side;

	bps_half_dot #(
		.COMPONENT_BITS(CB),
		.SIDE_W(SIDE_W)
	) u_half_dot (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s1),
		.sum_x(sum_x_s1),
		.sum_y(sum_y_s1),
		.sum_z(sum_z_s1),
		.nrm_x(nx_s1),
		.nrm_y(ny_s1),
		.nrm_z(nz_s1),
		.in_side(side_s1),
		.out_valid(hd_valid),
		.cos_q16(hd_cos),
		.out_side(hd_side)
	);

	// cos^shininess
	logic               pw_valid;
	logic [POW_W-1:0]   pw_val;
	logic [SIDE_W-1:0]  pw_side;

	bps_pow #(
		.SIDE_W(SIDE_W)
	) u_pow (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(hd_valid),
		.base(hd_cos),
		.expo(shininess_q),
		.in_side(hd_side),
		.out_valid(pw_valid),
		.pow_q16(pw_val),
		.out_side(pw_side)
	);

	// color combine: four stages, s2 to s4 one multiply deep each, s5 an add
	logic               vld_s2, vld_s3, vld_s4, done_s5;
	logic [40:0]        sp_s2;
	logic [31:0]        kdg_s2;
	logic [47:0]        light_s2, light_s3;
	logic [15:0]        g_s2;
	logic [44:0]        spec_s3;
	logic [2:0][19:0]   dtmp_s3;
	logic [2:0][32:0]   st_s4;
	logic [2:0][23:0]   dt_s4;
	logic [15:0]        red_s5, green_s5, blue_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			done_s5 <= 1'b0;
		end else begin
			vld_s2  <= pw_valid;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			done_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic [56:0] ksp;
		logic [56:0] spf;
		logic [47:0] kl;
		logic [60:0] sl;
		logic [35:0] dm;
		logic [15:0] lc;
		logic [15:0] mat;
		logic [33:0] sum;
		// s2: ks * pow, kd * geom
		ksp = 57'(spec_coef_q) * 57'(pw_val);
		sp_s2    <= ksp[56:16];
		kdg_s2   <= 32'(diff_coef_q) * 32'(pw_side[15:0]);
		g_s2     <= pw_side[15:0];
		light_s2 <= pw_side[63:16];
		// s3: specular times geometry (capped), diffuse times light
		spf = 57'(sp_s2) * 57'(g_s2);
		spec_s3  <= (spf > 57'(SPEC_CAP)) ? SPEC_CAP : spf[44:0];
		light_s3 <= light_s2;
		for (int ch = 0; ch < 3; ch++) begin
			lc = light_s2[47-16*ch -: 16];
			kl = 48'(kdg_s2) * 48'(lc);
			dtmp_s3[ch] <= kl[47:28];
		end
		// s4: specular times light, diffuse times material
		for (int ch = 0; ch < 3; ch++) begin
			lc = light_s3[47-16*ch -: 16];
			case (ch)
				0:       mat = mat_red_q;
				1:       mat = mat_green_q;
				default: mat = mat_blue_q;
			endcase
			sl = 61'(spec_s3) * 61'(lc);
			dm = 36'(dtmp_s3[ch]) * 36'(mat);
			st_s4[ch] <= sl[60:28];
			dt_s4[ch] <= dm[35:12];
		end
		// s5: add and saturate
		sum = 34'(st_s4[0]) + 34'(dt_s4[0]);
		red_s5   <= (sum > 34'd65535) ? 16'hFFFF : sum[15:0];
		sum = 34'(st_s4[1]) + 34'(dt_s4[1]);
		green_s5 <= (sum > 34'd65535) ? 16'hFFFF : sum[15:0];
		sum = 34'(st_s4[2]) + 34'(dt_s4[2]);
		blue_s5  <= (sum > 34'd65535) ? 16'hFFFF : sum[15:0];
	end

	assign done      = done_s5;
	assign out_red   = red_s5;
	assign out_green = green_s5;
	assign out_blue  = blue_s5;

endmodule

FILE: design/bps_checker.sv
`timescale 1ns / 1ps
// Port-level checks: fixed latency both ways, black light gives black.
module bps_checker #(
	parameter int COMPONENT_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [47:0] light_rgb,
	input logic        done,
	input logic [15:0] out_red,
	input logic [15:0] out_green,
	input logic [15:0] out_blue
);
	localparam int LAT = 2 * COMPONENT_BITS + 46;

	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction gave no result at the fixed latency");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transaction");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && light_rgb == 48'd0) |-> ##LAT
		(done && out_red == 16'd0 && out_green == 16'd0 && out_blue == 16'd0))
		else $error("zero light color gave a nonzero result");

endmodule

bind blinn_phong_shade_unit bps_checker #(
	.COMPONENT_BITS(COMPONENT_BITS)
) u_bps_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.light_rgb(light_rgb),
	.done(done),
	.out_red(out_red),
	.out_green(out_green),
	.out_blue(out_blue)
);

FILE: dv/blinn_phong_shade_unit_tb.sv
`timescale 1ns / 1ps
// Blinn-Phong shade unit testbench.
// A queue of light samples feeds a clocked driver; each accepted transaction is
// scored right away against a fixed-point shading predictor, and the expected
// color is queued. The monitor pops one expected color per done strobe and
// compares all three channels. Register settings change between phases, only
// once the pipeline has drained.
module blinn_phong_shade_unit_tb;
	import bps_pkg::*;

	localparam int CLK_HALF  = 10;
	localparam int LATENCY   = 78;
	localparam int DRAIN     = LATENCY + 20;
	localparam int MAX_CYCLES = 400000;
	localparam int RAND_PER_PHASE = 272;
	// cfg_index 6 and 7 map to nothing and must be ignored
	localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = 3'd7;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE    = 3'd6;

	typedef struct {
		logic [47:0]        light;
		logic signed [15:0] nx, ny, nz;
		logic signed [15:0] lx, ly, lz;
		logic signed [15:0] vx, vy, vz;
		logic [15:0]        geom;
	} sample_t;

	typedef struct {
		logic [15:0] red, green, blue;
	} color_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [47:0] light_rgb;
	logic signed [15:0] norm_x, norm_y, norm_z;
	logic signed [15:0] light_x, light_y, light_z;
	logic signed [15:0] view_x, view_y, view_z;
	logic [15:0] geom_factor;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;
	logic done;
	logic [15:0] out_red, out_green, out_blue;

	blinn_phong_shade_unit uut (.*);

	// Shadow copy of the register file
	logic [63:0] ks, kd, shine, mat_r, mat_g, mat_b;

	sample_t samples_q[$];
	color_t  colors_q[$];
	int      errors;
	int      shaded;
	int      cycles;
	bit      no_gaps;
	int      gap_left;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// --- predictor ---------------------------------------------------------

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// log2 of a Q.16 base, signed Q.16
	function automatic longint log2_fix(logic [63:0] b);
		int p;
		logic [63:0] m;
		longint frac;
		p = 0;
		frac = 0;
		while (p < 63 && (b >> (p + 1)) != 0)
			p++;
		m = (p <= 30) ? (b << (30 - p)) : (b >> (p - 30));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return longint'(p - 16) * 65536 + frac;
	endfunction

	// 2^t, t signed Q.16, result Q.16 capped at 2^40
	function automatic logic [63:0] exp2_fix(longint t);
		longint ip;
		longint sh;
		logic [63:0] f, mant, fac, r, a;
		mant = 64'd1 << 30;
		fac = 64'd1 << 31;
		if (t >= 0) begin
			ip = t / 65536;
			f = t % 65536;
		end else begin
			a = -t;
			ip = -longint'((a + 65535) / 65536);
			f = t - ip * 65536;
		end
		for (int k = 1; k <= 16; k++) begin
			fac = int_sqrt(fac << 30);
			if (f[16-k])
				mant = (mant * fac) >> 30;
		end
		if (ip <= 14) begin
			sh = 14 - ip;
			r = (sh >= 63) ? 0 : (mant >> sh);
		end else if (ip > 24) begin
			r = 64'd1 << 40;
		end else begin
			r = mant << (ip - 14);
		end
		return (r > (64'd1 << 40)) ? (64'd1 << 40) : r;
	endfunction

	function automatic logic [63:0] cos_pow(logic [63:0] b, logic [63:0] e);
		longint t;
		if (e == 0)
			return 64'd65536;
		if (b == 0)
			return 0;
		t = log2_fix(b) * longint'(e);
		if (t >= 0)
			t = t / 256;
		else
			t = -longint'((64'(-t) + 255) / 256);
		return exp2_fix(t);
	endfunction

	function automatic color_t shade(sample_t s);
		longint sx, sy, sz, q, len, hx, hy, hz, d;
		logic [63:0] cosv, pw, spec, kdg, lc, st, dt, sum;
		logic [63:0] mats[3];
		logic [15:0] ch[3];
		color_t c;
		sx = longint'(s.lx) + longint'(s.vx);
		sy = longint'(s.ly) + longint'(s.vy);
		sz = longint'(s.lz) + longint'(s.vz);
		q = sx * sx + sy * sy + sz * sz;
		cosv = 0;
		// zero half vector leaves the cosine at 0
		if (q != 0) begin
			len = int_sqrt(q);
			hx = sx * 16384 / len;
			hy = sy * 16384 / len;
			hz = sz * 16384 / len;
			d = hx * s.nx + hy * s.ny + hz * s.nz;
			// back-facing: cosine stays 0; Q.14 -> Q.16
			if (d > 0)
				cosv = (64'(d) >> 14) << 2;
		end
		pw = cos_pow(cosv, shine);
		spec = ((ks * pw) >> 16) * s.geom;
		if (spec > (64'd1 << 44))
			spec = 64'd1 << 44;
		kdg = kd * s.geom;
		mats[0] = mat_r;
		mats[1] = mat_g;
		mats[2] = mat_b;
		for (int i = 0; i < 3; i++) begin
			lc = (s.light >> (32 - 16 * i)) & 64'hFFFF;
			st = (spec * lc) >> 28;
			dt = (((kdg * lc) >> 28) * mats[i]) >> 12;
			sum = st + dt;
			ch[i] = (sum > 64'hFFFF) ? 16'hFFFF : sum[15:0];
		end
		c.red = ch[0];
		c.green = ch[1];
		c.blue = ch[2];
		return c;
	endfunction

	// --- driver ------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t s;
		logic next_start;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
			light_rgb <= '0;
			{norm_x, norm_y, norm_z} <= '0;
			{light_x, light_y, light_z} <= '0;
			{view_x, view_y, view_z} <= '0;
			geom_factor <= '0;
		end else begin
			// transaction taken on this edge: score it now
			if (start && !busy) begin
				s.light = light_rgb;
				s.nx = norm_x; s.ny = norm_y; s.nz = norm_z;
				s.lx = light_x; s.ly = light_y; s.lz = light_z;
				s.vx = view_x; s.vy = view_y; s.vz = view_z;
				s.geom = geom_factor;
				colors_q.push_back(shade(s));
			end
			if (start && busy) begin
				next_start = 1'b1; // hold current item
			end else if (gap_left > 0) begin
				next_start = 1'b0;
				gap_left <= gap_left - 1;
			end else if (samples_q.size() > 0) begin
				s = samples_q.pop_front();
				light_rgb <= s.light;
				norm_x <= s.nx; norm_y <= s.ny; norm_z <= s.nz;
				light_x <= s.lx; light_y <= s.ly; light_z <= s.lz;
				view_x <= s.vx; view_y <= s.vy; view_z <= s.vz;
				geom_factor <= s.geom;
				next_start = 1'b1;
				gap_left <= pick_gap();
			end else begin
				next_start = 1'b0;
			end
			start <= next_start;
		end
	end

	// --- monitor -----------------------------------------------------------

	always @(posedge clk) begin
		color_t e;
		if (arst_n && done) begin
			if (colors_q.size() == 0) begin
				$error("unexpected result r=%h g=%h b=%h", out_red, out_green, out_blue);
				errors++;
			end else begin
				e = colors_q.pop_front();
				shaded++;
				if (out_red !== e.red) begin
					$error("out_red expected %h got %h", e.red, out_red);
					errors++;
				end
				if (out_green !== e.green) begin
					$error("out_green expected %h got %h", e.green, out_green);
					errors++;
				end
				if (out_blue !== e.blue) begin
					$error("out_blue expected %h got %h", e.blue, out_blue);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// --- stimulus ----------------------------------------------------------

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SPEC_COEF: ks = 64'(val);
			REG_DIFF_COEF: kd = 64'(val);
			REG_SHININESS: shine = 64'(val);
			REG_MAT_RED:   mat_r = 64'(val);
			REG_MAT_GREEN: mat_g = 64'(val);
			REG_MAT_BLUE:  mat_b = 64'(val);
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [15:0] s_ks, logic [15:0] s_kd, logic [15:0] s_sh,
			logic [15:0] r, logic [15:0] g, logic [15:0] b);
		reg_write(REG_SPEC_COEF, s_ks);
		reg_write(REG_DIFF_COEF, s_kd);
		reg_write(REG_SHININESS, s_sh);
		reg_write(REG_MAT_RED, r);
		reg_write(REG_MAT_GREEN, g);
		reg_write(REG_MAT_BLUE, b);
	endtask

	// pipeline empty and latency waited out
	task automatic drain();
		while (samples_q.size() > 0 || colors_q.size() > 0 || start)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic sample_t mk(logic [47:0] lt, int nx, int ny, int nz, int lx, int ly,
			int lz, int vx, int vy, int vz, logic [15:0] g);
		sample_t s;
		s.light = lt;
		s.nx = 16'(nx); s.ny = 16'(ny); s.nz = 16'(nz);
		s.lx = 16'(lx); s.ly = 16'(ly); s.lz = 16'(lz);
		s.vx = 16'(vx); s.vy = 16'(vy); s.vz = 16'(vz);
		s.geom = g;
		return s;
	endfunction

	function automatic logic signed [15:0] rnd_comp(bit wide);
		if (wide)
			return 16'($urandom);
		return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
	endfunction

	// Mostly unit-range vectors with the normal steered toward the half vector
	// so the specular path is exercised; the rest full-range noise.
	function automatic sample_t rnd_sample();
		sample_t s;
		int r;
		r = $urandom_range(0, 99);
		s.light = 48'({$urandom, $urandom});
		s.geom = 16'($urandom);
		if (r < 15) begin
			s.nx = 16'($urandom); s.ny = 16'($urandom); s.nz = 16'($urandom);
			s.lx = 16'($urandom); s.ly = 16'($urandom); s.lz = 16'($urandom);
			s.vx = 16'($urandom); s.vy = 16'($urandom); s.vz = 16'($urandom);
		end else begin
			s.lx = rnd_comp(0); s.ly = rnd_comp(0); s.lz = rnd_comp(0);
			s.vx = rnd_comp(0); s.vy = rnd_comp(0); s.vz = rnd_comp(0);
			if (r < 70) begin
				s.nx = 16'((32'(s.lx) + 32'(s.vx)) / 2 + $signed($urandom_range(0, 400)) - 200);
				s.ny = 16'((32'(s.ly) + 32'(s.vy)) / 2 + $signed($urandom_range(0, 400)) - 200);
				s.nz = 16'((32'(s.lz) + 32'(s.vz)) / 2 + $signed($urandom_range(0, 400)) - 200);
			end else begin
				s.nx = rnd_comp(0); s.ny = rnd_comp(0); s.nz = rnd_comp(0);
			end
		end
		if (r >= 90)
			s.light = {3{16'($urandom_range(0, 8192))}};
		return s;
	endfunction

	task automatic random_phase();
		no_gaps = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < RAND_PER_PHASE; i++)
			samples_q.push_back(rnd_sample());
		drain();
	endtask

	initial begin
		errors = 0;
		shaded = 0;
		cycles = 0;
		no_gaps = 0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ks = 0; kd = 16384; shine = 2560;
		mat_r = 4096; mat_g = 4096; mat_b = 4096;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed set, with a visible specular term
		set_regs(16'd16384, 16'd16384, 16'd2560, 16'd4096, 16'd4096, 16'd4096);
		samples_q.push_back(mk('0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
		samples_q.push_back(mk({3{16'h1000}}, 0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 16'd16384));
		samples_q.push_back(mk({3{16'hFFFF}}, 0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 16'hFFFF));
		// light opposite to view: zero half vector
		samples_q.push_back(mk({3{16'h1000}}, 0, 0, 16384, 16384, 0, 0, -16384, 0, 0, 16'd16384));
		// back-facing half vector
		samples_q.push_back(mk({3{16'h1000}}, 0, 0, -16384, 0, 0, 16384, 0, 0, 16384, 16'd16384));
		// oblique, partial cosine
		samples_q.push_back(mk(48'h1000_2000_3000, 0, 11585, 11585, 0, 0, 16384, 0, 16384, 0,
			16'd16384));
		// extreme components everywhere
		samples_q.push_back(mk(48'hFFFF_FFFF_FFFF, 32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767, 16'hFFFF));
		samples_q.push_back(mk(48'hFFFF_0000_FFFF, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768, 16'hFFFF));
		samples_q.push_back(mk(48'h0000_FFFF_0000, 32767, -32768, 32767, -32768, 32767, -32768,
			32767, -32768, 32767, 16'h8000));
		// oversized normal: cosine above one
		samples_q.push_back(mk({3{16'h0800}}, 0, 0, 32767, 0, 0, 16384, 0, 0, 16384, 16'd16384));
		samples_q.push_back(mk(48'h0001_0001_0001, 1, 1, 1, 1, 0, 0, 0, 1, 0, 16'd1));
		drain();

		// zero exponent: pow is one even for a zero cosine
		set_regs(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		reg_write(IDX_UNMAPPED, 16'hFFFF);
		reg_write(IDX_SPARE, 16'h1234);
		samples_q.push_back(mk({3{16'h1000}}, 0, 0, -16384, 0, 0, 16384, 0, 0, 16384, 16'd16384));
		samples_q.push_back(mk({3{16'h1000}}, 0, 0, 16384, 16384, 0, 0, -16384, 0, 0, 16'd16384));
		samples_q.push_back(mk({3{16'h1000}}, 0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 16'd16384));
		drain();

		// random phases over a spread of settings, extremes included
		set_regs(16'd0, 16'd16384, 16'd2560, 16'd4096, 16'd4096, 16'd4096);
		random_phase();
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_phase();
		set_regs(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		random_phase();
		set_regs(16'd16384, 16'd8192, 16'd256, 16'd4096, 16'd2048, 16'd1024);
		random_phase();
		set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(1, 8192)), 16'($urandom),
			16'($urandom), 16'($urandom));
		random_phase();
		set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
		random_phase();

		$display("shaded %0d samples over eight register settings, %0d cycles", shaded, cycles);
		$display("covered zero/back-facing half vectors, zero exponent, saturation, noise");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
design/bps_pkg.sv
design/bps_half_dot.sv
design/bps_pow.sv
design/blinn_phong_shade_unit.sv
design/bps_checker.sv
dv/blinn_phong_shade_unit_tb.sv
